### rtl/bicolor_status_led_blinker_defines.svh
// Assertion macros for the bicolour status LED blinker.
// No dependencies; taken in by `include where assertions are written.
`ifndef BICOLOR_STATUS_LED_BLINKER_DEFINES_SVH
`define BICOLOR_STATUS_LED_BLINKER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define BSLB_ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bslb check failed");
// Checked at every edge, reset included.
`define BSLB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bslb check failed");
`else
`define BSLB_ASSERT_RST(label, clk, rstn, prop)
`define BSLB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/bslb_pkg.sv
// Package for the bicolour status LED blinker: types, command, drive and register codes.
// No dependencies.
`timescale 1ns / 1ps

package bslb_pkg;

    // Width of the stored toggle time; elapsed time wraps modulo 2**TIME_BITS.
    localparam int TIME_BITS = 32;

    typedef logic [TIME_BITS-1:0] time_ms_t;
    typedef logic [7:0]           pin_t;
    typedef logic [7:0]           led_cmd_t;
    typedef logic [15:0]          period_t;
    typedef logic [1:0]           drive_t;
    typedef logic [1:0]           reg_idx_t;

    // Command codes; 7..255 are held but do nothing.
    localparam led_cmd_t CMD_OFF              = 8'd0;
    localparam led_cmd_t CMD_GREEN            = 8'd1;
    localparam led_cmd_t CMD_RED              = 8'd2;
    localparam led_cmd_t CMD_BLINK_GREEN_SLOW = 8'd3;
    localparam led_cmd_t CMD_BLINK_GREEN_FAST = 8'd4;
    localparam led_cmd_t CMD_BLINK_RED_SLOW   = 8'd5;
    localparam led_cmd_t CMD_BLINK_RED_FAST   = 8'd6;

    // Pin drive codes.
    localparam drive_t DRIVE_HIZ   = 2'd0;
    localparam drive_t DRIVE_GREEN = 2'd1;
    localparam drive_t DRIVE_RED   = 2'd2;

    // Register indexes (byte address = 4 * index).
    localparam reg_idx_t REG_FIRST_LED_PIN    = 2'd0;
    localparam reg_idx_t REG_SECOND_LED_PIN   = 2'd1;
    localparam reg_idx_t REG_SLOW_HALF_PERIOD = 2'd2;
    localparam reg_idx_t REG_FAST_HALF_PERIOD = 2'd3;

    // Reset values of the registers.
    localparam pin_t    RST_FIRST_LED_PIN    = 8'd1;
    localparam pin_t    RST_SECOND_LED_PIN   = 8'd2;
    localparam period_t RST_SLOW_HALF_PERIOD = 16'd500;
    localparam period_t RST_FAST_HALF_PERIOD = 16'd100;

endpackage

### rtl/bicolor_status_led_blinker.sv
// Top level of the bicolour status LED blinker: input register, update logic, result register.
// Depends on bslb_pkg and bicolor_status_led_blinker_defines.svh.
`timescale 1ns / 1ps
`include "bicolor_status_led_blinker_defines.svh"

// Usage
// - Input channel (s_valid/s_ready): one item per poll pass with an optional pair of
//   (pin, command) entries, gated by s_has_command, and the current time in ms.
// - Result channel (m_valid/m_ready): one item per input item, the drive of both LED pins
//   (0 high impedance, 1 driven high = green, 2 driven low = red).
// - APB port: four registers at 0x0, 0x4, 0x8, 0xC (first pin, second pin, slow and fast
//   half period). Write only while the block is idle; pready is tied high.
// - Flow: an accepted item is registered in the input register, processed, and loaded into
//   the result register once it can advance; m_valid is high from then on.
// - Throughput: one item per cycle while results are taken. The single update stage (command
//   apply, one wrapping subtract and compare per LED) sets that figure.
// - Stall: while a result waits, the input register still takes one more item; s_ready
//   then falls until the result is taken. No item is lost or repeated.
// - Reset (aresetn low, synchronous): both LEDs off and high impedance, blink phase and
//   toggle times zero, registers back to pins 1 and 2, 500 ms and 100 ms; channels empty.
module bicolor_status_led_blinker (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_has_command,
    input  bslb_pkg::pin_t       s_pin_first,
    input  bslb_pkg::led_cmd_t   s_cmd_first,
    input  bslb_pkg::pin_t       s_pin_second,
    input  bslb_pkg::led_cmd_t   s_cmd_second,
    input  logic [31:0]          s_now_ms,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output bslb_pkg::drive_t     m_first_drive,
    output bslb_pkg::drive_t     m_second_drive,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import bslb_pkg::*;

    // configuration registers
    pin_t     first_pin_reg;
    pin_t     second_pin_reg;
    period_t  slow_half_reg;
    period_t  fast_half_reg;
    reg_idx_t cfg_idx;
    logic     cfg_wr;

    // input register
    logic     in_valid_reg;
    logic     in_has_cmd_reg;
    pin_t     in_pin_reg [2];
    led_cmd_t in_cmd_reg [2];
    time_ms_t in_now_reg;

    // per-LED state
    led_cmd_t led_cmd_reg  [2];
    logic     phase_reg    [2];
    time_ms_t last_reg     [2];
    drive_t   drive_reg    [2];
    led_cmd_t led_cmd_next [2];
    logic     phase_next   [2];
    time_ms_t last_next    [2];
    drive_t   drive_next   [2];

    // result register
    logic     out_valid_reg;
    drive_t   out_drive_reg [2];

    // update helpers
    time_ms_t elapsed  [2];
    time_ms_t interval [2];
    drive_t   colour   [2];
    logic     blinking [2];

    logic     in_take;
    logic     advance;

    // ---------------------------------------------------------------- handshakes
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    assign m_valid        = out_valid_reg;
    assign m_first_drive  = out_drive_reg[0];
    assign m_second_drive = out_drive_reg[1];

    // ---------------------------------------------------------------- APB
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_FIRST_LED_PIN:    prdata = {24'd0, first_pin_reg};
            REG_SECOND_LED_PIN:   prdata = {24'd0, second_pin_reg};
            REG_SLOW_HALF_PERIOD: prdata = {16'd0, slow_half_reg};
            REG_FAST_HALF_PERIOD: prdata = {16'd0, fast_half_reg};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_pin_reg  <= RST_FIRST_LED_PIN;
            second_pin_reg <= RST_SECOND_LED_PIN;
            slow_half_reg  <= RST_SLOW_HALF_PERIOD;
            fast_half_reg  <= RST_FAST_HALF_PERIOD;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FIRST_LED_PIN:    first_pin_reg  <= pwdata[7:0];
                REG_SECOND_LED_PIN:   second_pin_reg <= pwdata[7:0];
                REG_SLOW_HALF_PERIOD: slow_half_reg  <= pwdata[15:0];
                REG_FAST_HALF_PERIOD: fast_half_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_has_cmd_reg <= s_has_command;
            in_pin_reg[0]  <= s_pin_first;
            in_cmd_reg[0]  <= s_cmd_first;
            in_pin_reg[1]  <= s_pin_second;
            in_cmd_reg[1]  <= s_cmd_second;
            in_now_reg     <= time_ms_t'(s_now_ms);
        end
    end

    // ---------------------------------------------------------------- update logic
    // First pair applied before the second, so the second wins on the same LED.
    // Equal configured pins: the first LED takes the command.
    always_comb begin
        led_cmd_next = led_cmd_reg;
        phase_next   = phase_reg;
        last_next    = last_reg;
        drive_next   = drive_reg;

        for (int j = 0; j < 2; j++) begin
            if (in_has_cmd_reg && (in_pin_reg[j] != 8'd0)) begin
                if (in_pin_reg[j] == first_pin_reg) begin
                    led_cmd_next[0] = in_cmd_reg[j];
                    if (in_cmd_reg[j] <= CMD_RED) begin
                        drive_next[0] = in_cmd_reg[j][1:0];
                    end
                end else if (in_pin_reg[j] == second_pin_reg) begin
                    led_cmd_next[1] = in_cmd_reg[j];
                    if (in_cmd_reg[j] <= CMD_RED) begin
                        drive_next[1] = in_cmd_reg[j][1:0];
                    end
                end
            end
        end

        // blink: toggle once the wrapping elapsed time reaches the half period
        for (int k = 0; k < 2; k++) begin
            blinking[k] = (led_cmd_next[k] >= CMD_BLINK_GREEN_SLOW) &&
                          (led_cmd_next[k] <= CMD_BLINK_RED_FAST);
            interval[k] = ((led_cmd_next[k] == CMD_BLINK_GREEN_SLOW) ||
                           (led_cmd_next[k] == CMD_BLINK_RED_SLOW)) ?
                          time_ms_t'(slow_half_reg) : time_ms_t'(fast_half_reg);
            colour[k]   = ((led_cmd_next[k] == CMD_BLINK_GREEN_SLOW) ||
                           (led_cmd_next[k] == CMD_BLINK_GREEN_FAST)) ?
                          DRIVE_GREEN : DRIVE_RED;
            elapsed[k]  = in_now_reg - last_reg[k];
            if (blinking[k] && (elapsed[k] >= interval[k])) begin
                phase_next[k] = !phase_reg[k];
                drive_next[k] = phase_reg[k] ? DRIVE_HIZ : colour[k];
                last_next[k]  = in_now_reg;
            end
        end
    end

    // ---------------------------------------------------------------- state and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                led_cmd_reg[k] <= CMD_OFF;
                phase_reg[k]   <= 1'b0;
                last_reg[k]    <= '0;
                drive_reg[k]   <= DRIVE_HIZ;
            end
        end else if (advance) begin
            led_cmd_reg <= led_cmd_next;
            phase_reg   <= phase_next;
            last_reg    <= last_next;
            drive_reg   <= drive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_drive_reg <= drive_next;
        end
    end

    // ---------------------------------------------------------------- assertions
    // A steady command always shows on its pin.
    `BSLB_ASSERT_RST(a_steady_first, aclk, aresetn,
        (led_cmd_reg[0] <= CMD_RED) |-> (drive_reg[0] == led_cmd_reg[0][1:0]))
    `BSLB_ASSERT_RST(a_steady_second, aclk, aresetn,
        (led_cmd_reg[1] <= CMD_RED) |-> (drive_reg[1] == led_cmd_reg[1][1:0]))
    // Input side stalls only with both registers full and the receiver stalling.
    `BSLB_ASSERT_ALWAYS(a_stall_cause, aclk,
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
    // Every processed item lands in the result register.
    `BSLB_ASSERT_RST(a_advance_result, aclk, aresetn,
        advance |=> out_valid_reg)

endmodule

### tb/sv/tb_bicolor_status_led_blinker.sv
// Self-checking testbench for bicolor_status_led_blinker: directed and random poll items,
// APB register set-up between phases, and a local LED model that predicts each result item.
// Depends on bslb_pkg and the block's RTL; nothing else.
`timescale 1ns / 1ps

module tb_bicolor_status_led_blinker;
    import bslb_pkg::*;

    localparam int CLK_HALF_NS     = 5;
    localparam int RESET_CYCLES    = 9;
    // The result register follows the input register; spare cycles after draining cover it.
    localparam int SETTLE_CYCLES   = 4;
    localparam int LONG_HOLD       = 120;   // receiver hold-off, long enough to back up the input
    localparam int QUIET_LIMIT     = 2000;  // cycles without any handshake before giving up
    localparam int RANDOM_PHASES   = 8;
    localparam int POLLS_PER_PHASE = 144;
    localparam int MAX_REPORTS     = 60;

    localparam pin_t     NO_PIN            = 8'd0;
    localparam pin_t     TOP_PIN           = 8'hFF;
    localparam led_cmd_t CMD_FIRST_UNKNOWN = CMD_BLINK_RED_FAST + 8'd1;
    localparam led_cmd_t CMD_LAST_UNKNOWN  = 8'hFF;
    localparam period_t  PERIOD_MIN        = 16'd1;
    localparam period_t  PERIOD_MAX        = 16'hFFFF;

    // One pass of the poll loop.
    typedef struct {
        logic     has_cmd;
        pin_t     pin_a;
        led_cmd_t cmd_a;
        pin_t     pin_b;
        led_cmd_t cmd_b;
        time_ms_t now;
    } poll_t;

    // Drive of both pins: [0] first LED, [1] second LED.
    typedef logic [1:0][1:0] led_pair_t;

    // ------------------------------------------------------------------
    // Clock, block ports and the block itself
    // ------------------------------------------------------------------
    logic aclk;
    always begin
        aclk = 1'b0;
        #CLK_HALF_NS;
        aclk = 1'b1;
        #CLK_HALF_NS;
    end

    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_has_command  = 1'b0;
    pin_t        s_pin_first    = '0;
    led_cmd_t    s_cmd_first    = '0;
    pin_t        s_pin_second   = '0;
    led_cmd_t    s_cmd_second   = '0;
    logic [31:0] s_now_ms       = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    drive_t      m_first_drive;
    drive_t      m_second_drive;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [3:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    bicolor_status_led_blinker DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_has_command  (s_has_command),
        .s_pin_first    (s_pin_first),
        .s_cmd_first    (s_cmd_first),
        .s_pin_second   (s_pin_second),
        .s_cmd_second   (s_cmd_second),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_first_drive  (m_first_drive),
        .m_second_drive (m_second_drive),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // LED model: its own copy of the registers and of the per-LED state
    // ------------------------------------------------------------------
    pin_t      cfg_pin [2];
    period_t   cfg_slow;
    period_t   cfg_fast;
    led_cmd_t  held_cmd [2];
    logic      lit [2];         // blink phase, 1 while the colour is showing
    time_ms_t  toggled_at [2];
    led_pair_t drive_now;

    poll_t     pending_polls [$];   // items waiting for the driver
    led_pair_t expected_leds [$];   // predicted result items, oldest first
    poll_t     next_poll;           // item currently offered on the input channel
    led_pair_t got_leds;
    led_pair_t want_leds;

    int       issued_polls   = 0;
    int       finished_polls = 0;
    int       fail_count     = 0;
    int       send_gap       = 0;
    int       stall_left     = 0;
    int       quiet_cycles   = 0;
    bit       in_taken       = 1'b0;
    bit       no_idle        = 1'b0;
    bit       hold_req       = 1'b0;
    time_ms_t clock_ms       = '0;

    // A command is stored by the first LED whose pin matches, so equal pins favour LED 0.
    function automatic void take_command(pin_t pin, led_cmd_t cmd);
        int k;
        if (pin == NO_PIN)
            return;
        if (pin == cfg_pin[0])
            k = 0;
        else if (pin == cfg_pin[1])
            k = 1;
        else
            return;
        held_cmd[k] = cmd;
        // steady codes share their encoding with the drive codes
        if (cmd <= CMD_RED)
            drive_now[k] = cmd[1:0];
    endfunction

    function automatic void run_blink(int k, time_ms_t now);
        period_t half;
        drive_t  colour;
        case (held_cmd[k])
            CMD_BLINK_GREEN_SLOW: begin
                half = cfg_slow;
                colour = DRIVE_GREEN;
            end
            CMD_BLINK_GREEN_FAST: begin
                half = cfg_fast;
                colour = DRIVE_GREEN;
            end
            CMD_BLINK_RED_SLOW: begin
                half = cfg_slow;
                colour = DRIVE_RED;
            end
            CMD_BLINK_RED_FAST: begin
                half = cfg_fast;
                colour = DRIVE_RED;
            end
            default: return;    // steady or unknown: nothing moves
        endcase
        // elapsed time wraps with the 32-bit millisecond counter
        if (time_ms_t'(now - toggled_at[k]) >= half) begin
            lit[k] = !lit[k];
            drive_now[k] = lit[k] ? colour : DRIVE_HIZ;
            toggled_at[k] = now;
        end
    endfunction

    function automatic led_pair_t predict_leds(poll_t p);
        if (p.has_cmd) begin
            take_command(p.pin_a, p.cmd_a);
            take_command(p.pin_b, p.cmd_b);
        end
        run_blink(0, p.now);
        run_blink(1, p.now);
        return drive_now;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic pin_t pick_pin();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return NO_PIN;
        if (r < 5)
            return cfg_pin[0];
        if (r < 8)
            return cfg_pin[1];
        return pin_t'($urandom_range(0, TOP_PIN));
    endfunction

    function automatic led_cmd_t pick_cmd();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return led_cmd_t'($urandom_range(CMD_OFF, CMD_BLINK_RED_FAST));
        if (r == 8)
            return led_cmd_t'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
        return led_cmd_t'($urandom_range(0, CMD_LAST_UNKNOWN));
    endfunction

    function automatic period_t pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return PERIOD_MIN;
        if (r == 1)
            return PERIOD_MAX;
        if (r < 7)
            return period_t'($urandom_range(PERIOD_MIN, 2000));
        return period_t'($urandom_range(PERIOD_MIN, PERIOD_MAX));
    endfunction

    // Random poll: the clock mostly steps by amounts near the half periods, so blinks
    // keep toggling, with exact thresholds and arbitrary jumps (wrap included) mixed in.
    function automatic poll_t make_poll();
        poll_t p;
        case ($urandom_range(0, 9))
            0: clock_ms = clock_ms;
            1, 2, 3, 4: clock_ms += $urandom_range(0, 2 * cfg_fast);
            5, 6, 7: clock_ms += $urandom_range(0, 2 * cfg_slow);
            8: clock_ms += ($urandom_range(0, 1) ? cfg_slow : cfg_fast) - $urandom_range(0, 1);
            default: clock_ms = $urandom();
        endcase
        p.has_cmd = ($urandom_range(0, 9) < 6);
        p.pin_a = pick_pin();
        p.cmd_a = pick_cmd();
        p.pin_b = pick_pin();
        p.cmd_b = pick_cmd();
        p.now = clock_ms;
        return p;
    endfunction

    function automatic poll_t poll_of(logic has, pin_t pa, led_cmd_t ca, pin_t pb,
                                      led_cmd_t cb, time_ms_t now);
        poll_t p;
        p.has_cmd = has;
        p.pin_a = pa;
        p.cmd_a = ca;
        p.pin_b = pb;
        p.cmd_b = cb;
        p.now = now;
        return p;
    endfunction

    task automatic queue_poll(poll_t p);
        pending_polls = {pending_polls, p};
        issued_polls++;
    endtask

    task automatic report_mismatch(string msg);
        if (fail_count < MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Every item yields one result item, so the block is idle once the counts agree.
    task automatic wait_drained();
        do @(negedge aclk); while (finished_polls != issued_polls);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // APB write, then a read-back of the same register straight after.
    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        logic [31:0] readback;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        readback = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FIRST_LED_PIN:    cfg_pin[0] = value[7:0];
            REG_SECOND_LED_PIN:   cfg_pin[1] = value[7:0];
            REG_SLOW_HALF_PERIOD: cfg_slow = value[15:0];
            REG_FAST_HALF_PERIOD: cfg_fast = value[15:0];
            default: ;
        endcase
        if (readback !== value)
            report_mismatch($sformatf("register %0d reads %0h, written %0h", idx, readback, value));
    endtask

    // ------------------------------------------------------------------
    // Input driver: changes at the falling edge, takes items from pending_polls.
    // in_taken tells it the offered item went in at the last rising edge.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_polls.size() != 0) begin
                next_poll = pending_polls.pop_front();
                s_has_command <= next_poll.has_cmd;
                s_pin_first <= next_poll.pin_a;
                s_cmd_first <= next_poll.cmd_a;
                s_pin_second <= next_poll.pin_b;
                s_cmd_second <= next_poll.cmd_b;
                s_now_ms <= next_poll.now;
                s_valid <= 1'b1;
                send_gap = no_idle ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off on request that
    // backs the block up until it refuses input.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result item against the oldest prediction, and
    // predicts a new one for each item taken in.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                finished_polls++;
                got_leds = {m_second_drive, m_first_drive};
                if (expected_leds.size() == 0) begin
                    report_mismatch($sformatf("result item %0h with none expected", got_leds));
                end else begin
                    want_leds = expected_leds.pop_front();
                    for (int k = 0; k < 2; k++)
                        if (got_leds[k] !== want_leds[k])
                            report_mismatch($sformatf("result %0d, LED %0d drive %0d, want %0d",
                                                      finished_polls, k, got_leds[k],
                                                      want_leds[k]));
                end
            end
            if (s_valid && s_ready)
                expected_leds = {expected_leds, predict_leds(next_poll)};
        end
    end

    // Watchdog: a long run of cycles with no handshake on either channel ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed items at the reset settings, then random phases,
    // each with its own register settings written while the block is idle.
    // ------------------------------------------------------------------
    initial begin : stimulus
        pin_t    pa;
        pin_t    pb;
        period_t slow;
        period_t fast;

        cfg_pin[0] = RST_FIRST_LED_PIN;
        cfg_pin[1] = RST_SECOND_LED_PIN;
        cfg_slow = RST_SLOW_HALF_PERIOD;
        cfg_fast = RST_FAST_HALF_PERIOD;
        for (int k = 0; k < 2; k++) begin
            held_cmd[k] = CMD_OFF;
            lit[k] = 1'b0;
            toggled_at[k] = '0;
        end
        drive_now = {DRIVE_HIZ, DRIVE_HIZ};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed part, pins 1 and 2, slow 500 ms, fast 100 ms.
        // pairs present but flag clear: ignored
        queue_poll(poll_of(1'b0, RST_FIRST_LED_PIN, CMD_GREEN, RST_SECOND_LED_PIN, CMD_RED, 5));
        queue_poll(poll_of(1'b1, RST_FIRST_LED_PIN, CMD_GREEN, RST_SECOND_LED_PIN, CMD_RED, 10));
        // pin zero skipped, then LED 0 off
        queue_poll(poll_of(1'b1, NO_PIN, CMD_RED, RST_FIRST_LED_PIN, CMD_OFF, 20));
        // both pairs on LED 0: the second wins
        queue_poll(poll_of(1'b1, RST_FIRST_LED_PIN, CMD_GREEN, RST_FIRST_LED_PIN, CMD_RED, 30));
        // pin that matches neither LED
        queue_poll(poll_of(1'b1, TOP_PIN, CMD_GREEN, NO_PIN, CMD_OFF, 40));
        // start blinking; elapsed since time zero is past both half periods
        queue_poll(poll_of(1'b1, RST_FIRST_LED_PIN, CMD_BLINK_GREEN_SLOW,
                           RST_SECOND_LED_PIN, CMD_BLINK_RED_FAST, 1000));
        // one short of and exactly on the fast, then the slow, threshold
        queue_poll(poll_of(1'b0, NO_PIN, CMD_OFF, NO_PIN, CMD_OFF, 1099));
        queue_poll(poll_of(1'b0, NO_PIN, CMD_OFF, NO_PIN, CMD_OFF, 1100));
        queue_poll(poll_of(1'b0, NO_PIN, CMD_OFF, NO_PIN, CMD_OFF, 1499));
        queue_poll(poll_of(1'b0, NO_PIN, CMD_OFF, NO_PIN, CMD_OFF, 1500));
        // steady command mid-blink keeps phase and toggle time; blinking then resumes
        queue_poll(poll_of(1'b1, RST_SECOND_LED_PIN, CMD_GREEN, NO_PIN, CMD_OFF, 1550));
        queue_poll(poll_of(1'b1, RST_SECOND_LED_PIN, CMD_BLINK_RED_FAST, NO_PIN, CMD_OFF, 1600));
        // unknown codes freeze both LEDs, even long after
        queue_poll(poll_of(1'b1, RST_FIRST_LED_PIN, CMD_FIRST_UNKNOWN,
                           RST_SECOND_LED_PIN, CMD_LAST_UNKNOWN, 2000));
        queue_poll(poll_of(1'b0, NO_PIN, CMD_OFF, NO_PIN, CMD_OFF, 9000));
        // blinking across the wrap of the millisecond counter
        queue_poll(poll_of(1'b1, RST_FIRST_LED_PIN, CMD_BLINK_GREEN_FAST,
                           RST_SECOND_LED_PIN, CMD_BLINK_RED_SLOW, 32'hFFFF_FFF0));
        queue_poll(poll_of(1'b0, NO_PIN, CMD_OFF, NO_PIN, CMD_OFF, 32'hFFFF_FFFF));
        queue_poll(poll_of(1'b0, NO_PIN, CMD_OFF, NO_PIN, CMD_OFF, 32'h0000_0060));
        // all-ones fields, pin unmatched
        queue_poll(poll_of(1'b1, TOP_PIN, CMD_LAST_UNKNOWN, TOP_PIN, CMD_LAST_UNKNOWN,
                           32'hFFFF_FFFF));
        queue_poll(poll_of(1'b1, RST_FIRST_LED_PIN, CMD_OFF, RST_SECOND_LED_PIN, CMD_OFF, 32'h200));
        queue_poll(poll_of(1'b0, 8'hAA, 8'h55, 8'h55, 8'hAA, 32'hAAAA_5555));
        clock_ms = 32'hAAAA_5555;
        wait_drained();

        // Random phases. The first two take the register extremes, the rest are random,
        // a quarter of them with both LEDs on one pin.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    pa = TOP_PIN;
                    pb = TOP_PIN;
                    slow = PERIOD_MIN;
                    fast = PERIOD_MAX;
                end
                1: begin
                    pa = 8'd1;
                    pb = TOP_PIN;
                    slow = PERIOD_MAX;
                    fast = PERIOD_MIN;
                end
                default: begin
                    pa = pin_t'($urandom_range(1, TOP_PIN));
                    pb = ($urandom_range(0, 3) == 0) ? pa : pin_t'($urandom_range(1, TOP_PIN));
                    slow = pick_period();
                    fast = pick_period();
                end
            endcase
            apb_write(REG_FIRST_LED_PIN, 32'(pa));
            apb_write(REG_SECOND_LED_PIN, 32'(pb));
            apb_write(REG_SLOW_HALF_PERIOD, 32'(slow));
            apb_write(REG_FAST_HALF_PERIOD, 32'(fast));

            // one phase runs flat out on both sides; another holds the receiver off
            // for a long stretch while the sender keeps offering items
            no_idle = (ph == 4);
            if (ph == 2)
                hold_req = 1'b1;
            for (int n = 0; n < POLLS_PER_PHASE; n++)
                queue_poll(make_poll());
            // sender pauses here until every result item of the phase is back
            wait_drained();
        end

        if (expected_leds.size() != 0)
            report_mismatch($sformatf("%0d result items never arrived", expected_leds.size()));
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
